// ===== sv/qru_pkg.sv =====
// ----------------------------------------------------------------------------
// qru_pkg
// Operation codes and shared types of the quaternion rotation unit.
// ----------------------------------------------------------------------------
package qru_pkg;

  typedef enum logic [1:0] {
    OP_QMUL   = 2'd0,
    OP_ROTATE = 2'd1,
    OP_MATRIX = 2'd2,
    OP_CROSS  = 2'd3
  } op_e;

  localparam logic [1:0] ROW_LAST = 2'd3;

endpackage

// ===== sv/quaternion_rotation_unit_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_rotation_unit_top
// Fixed-point quaternion product, vector rotation, rotation matrix and cross
// product, saturating to the word range.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid_i / in_stall_o with op and the two quaternions.
//   Output channel: out_valid_o / out_stall_i with one result item per beat.
//   Products, cross and matrix items take 4 register stages from entry to
//   output: product, sum, second product, second sum/saturate.
//   Rotation uses both product/sum pairs in one pass (b*conj(a) in
//   stages 1-2, a*t in stages 3-4), so every op passes through the same stages.
//   Throughput: one item per cycle for ops 0, 1 and 3 unless the output
//   stalls. The matrix op holds the input stall while a row counter issues
//   rows 0..2, and takes the item with its last row, row 3.
//   A stall at the output freezes the whole pipeline; nothing is lost or
//   repeated. Reset clears all valid bits and the row counter.
// ----------------------------------------------------------------------------
module quaternion_rotation_unit_top #(
  parameter int FRAC_BITS = 12,
  parameter int WORD_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  op_i,
  input  logic signed [WORD_BITS-1:0] a_w_i,
  input  logic signed [WORD_BITS-1:0] a_x_i,
  input  logic signed [WORD_BITS-1:0] a_y_i,
  input  logic signed [WORD_BITS-1:0] a_z_i,
  input  logic signed [WORD_BITS-1:0] b_w_i,
  input  logic signed [WORD_BITS-1:0] b_x_i,
  input  logic signed [WORD_BITS-1:0] b_y_i,
  input  logic signed [WORD_BITS-1:0] b_z_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [WORD_BITS-1:0] out_x_o,
  output logic signed [WORD_BITS-1:0] out_y_o,
  output logic signed [WORD_BITS-1:0] out_z_o,
  output logic signed [WORD_BITS-1:0] out_w_o,
  output logic [1:0]                  row_o,
  output logic                        overflow_o,
  output logic                        last_o
);

  localparam int PW = 2 * WORD_BITS + 1;   // rounded product plus headroom
  localparam int SW = PW + 4;              // sum of up to 4 terms, times 2
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] ONE  = SW'(1) <<< FRAC_BITS;
  localparam logic signed [SW-1:0] WMAX = (SW'(1) <<< (WORD_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] WMIN = -(SW'(1) <<< (WORD_BITS - 1));

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [SW-1:0]        wide_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic [1:0] row;
    logic       last;
    logic       ovf;
  } ctl_t;

  // rounded product, ties toward plus infinity
  function automatic wide_t fmul(input word_t p, input word_t q);
    wide_t r;
    r = (wide_t'(p) * wide_t'(q)) + HALF;
    return r >>> FRAC_BITS;
  endfunction

  function automatic word_t sat(input wide_t v, inout logic ovf);
    if (v > WMAX) begin
      ovf = 1'b1;
      return WMAX[WORD_BITS-1:0];
    end
    if (v < WMIN) begin
      ovf = 1'b1;
      return WMIN[WORD_BITS-1:0];
    end
    return v[WORD_BITS-1:0];
  endfunction

  logic adv;
  assign adv = !out_valid_o || !out_stall_i;

  // --------------------------------------------------------------------------
  // Matrix row counter: holds the input for rows 0..2
  // --------------------------------------------------------------------------
  logic [1:0] row_q, row_d;
  logic       is_mat;
  assign is_mat = (op_i == qru_pkg::OP_MATRIX);
  assign in_stall_o = !adv || (in_valid_i && is_mat && row_q != qru_pkg::ROW_LAST);

  always_comb begin
    row_d = row_q;
    if (adv && in_valid_i && is_mat) row_d = row_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) row_q <= '0;
    else         row_q <= row_d;
  end

  // --------------------------------------------------------------------------
  // Stage 1: first products. 16 product slots p[i].
  // Rotate: operands v=(0,b) and c=conj(a) saturated. Matrix: the 9 terms.
  // --------------------------------------------------------------------------
  word_t qa [4];
  word_t qb [4];
  logic  c_ovf;
  word_t ca [4];
  wide_t p1 [16];

  always_comb begin
    qa[0] = a_w_i; qa[1] = a_x_i; qa[2] = a_y_i; qa[3] = a_z_i;
    qb[0] = b_w_i; qb[1] = b_x_i; qb[2] = b_y_i; qb[3] = b_z_i;
    c_ovf = 1'b0;
    ca[0] = a_w_i;
    for (int i = 1; i < 4; i++) ca[i] = sat(-wide_t'(qa[i]), c_ovf);
    for (int i = 0; i < 16; i++) p1[i] = '0;
    case (op_i)
      qru_pkg::OP_QMUL: begin
        for (int i = 0; i < 4; i++)
          for (int j = 0; j < 4; j++) p1[i*4+j] = fmul(qa[i], qb[j]);
      end
      qru_pkg::OP_ROTATE: begin
        // v * c with v[0] = 0
        for (int i = 1; i < 4; i++)
          for (int j = 0; j < 4; j++) p1[i*4+j] = fmul(qb[i], ca[j]);
      end
      qru_pkg::OP_MATRIX: begin
        p1[0] = fmul(a_x_i, a_x_i); p1[1] = fmul(a_y_i, a_y_i);
        p1[2] = fmul(a_z_i, a_z_i); p1[3] = fmul(a_x_i, a_y_i);
        p1[4] = fmul(a_x_i, a_z_i); p1[5] = fmul(a_y_i, a_z_i);
        p1[6] = fmul(a_w_i, a_x_i); p1[7] = fmul(a_w_i, a_y_i);
        p1[8] = fmul(a_w_i, a_z_i);
      end
      default: begin
        p1[0] = fmul(a_y_i, b_z_i); p1[1] = fmul(a_z_i, b_y_i);
        p1[2] = fmul(a_z_i, b_x_i); p1[3] = fmul(a_x_i, b_z_i);
        p1[4] = fmul(a_x_i, b_y_i); p1[5] = fmul(a_y_i, b_x_i);
      end
    endcase
  end

  ctl_t  c1_q;
  wide_t p1_q [16];
  word_t a1_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c1_q <= '0;
    else if (adv) begin
      c1_q.valid <= in_valid_i;
      c1_q.op    <= op_i;
      c1_q.row   <= is_mat ? row_q : 2'd0;
      c1_q.last  <= !is_mat || row_q == qru_pkg::ROW_LAST;
      c1_q.ovf   <= (op_i == qru_pkg::OP_ROTATE) && c_ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q <= p1;
      a1_q <= qa;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sums. Quaternion results land in s[0..3] (w,x,y,z).
  // Rotation saturates t here; its words go to the next multiply.
  // --------------------------------------------------------------------------
  wide_t s2 [4];
  word_t t2 [4];
  logic  ovf2;

  always_comb begin
    ovf2 = c1_q.ovf;
    for (int i = 0; i < 4; i++) s2[i] = '0;
    case (c1_q.op)
      qru_pkg::OP_QMUL, qru_pkg::OP_ROTATE: begin
        // p[i*4+j] = P[i]*Q[j]
        s2[0] = p1_q[0] - p1_q[5] - p1_q[10] - p1_q[15];
        s2[1] = p1_q[1] + p1_q[4] + p1_q[11] - p1_q[14];
        s2[2] = p1_q[2] + p1_q[8] + p1_q[13] - p1_q[7];
        s2[3] = p1_q[3] + p1_q[12] + p1_q[6] - p1_q[9];
      end
      qru_pkg::OP_MATRIX: begin
        case (c1_q.row)
          2'd0: begin
            s2[1] = ONE - ((p1_q[1] + p1_q[2]) <<< 1);
            s2[2] = (p1_q[3] - p1_q[8]) <<< 1;
            s2[3] = (p1_q[4] + p1_q[7]) <<< 1;
          end
          2'd1: begin
            s2[1] = (p1_q[3] + p1_q[8]) <<< 1;
            s2[2] = ONE - ((p1_q[0] + p1_q[2]) <<< 1);
            s2[3] = (p1_q[5] - p1_q[6]) <<< 1;
          end
          2'd2: begin
            s2[1] = (p1_q[4] - p1_q[7]) <<< 1;
            s2[2] = (p1_q[5] + p1_q[6]) <<< 1;
            s2[3] = ONE - ((p1_q[0] + p1_q[1]) <<< 1);
          end
          default: s2[0] = ONE;
        endcase
      end
      default: begin
        s2[1] = p1_q[0] - p1_q[1];
        s2[2] = p1_q[2] - p1_q[3];
        s2[3] = p1_q[4] - p1_q[5];
      end
    endcase
    for (int i = 0; i < 4; i++) t2[i] = sat(s2[i], ovf2);
  end

  ctl_t  c2_q;
  word_t t2_q [4];
  word_t a2_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c2_q <= '0;
    else if (adv) begin
      c2_q <= '{valid: c1_q.valid, op: c1_q.op, row: c1_q.row,
                last: c1_q.last, ovf: ovf2};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t2_q <= t2;
      a2_q <= a1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: second products a * t for rotation
  // --------------------------------------------------------------------------
  wide_t p3 [16];

  always_comb begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) p3[i*4+j] = fmul(a2_q[i], t2_q[j]);
  end

  ctl_t  c3_q;
  wide_t p3_q [16];
  word_t t3_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c3_q <= '0;
    else if (adv) c3_q <= c2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_q <= p3;
      t3_q <= t2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: final sum and saturation, output register
  // --------------------------------------------------------------------------
  word_t r4 [4];
  wide_t w4;
  logic  ovf4;

  always_comb begin
    ovf4 = c3_q.ovf;
    r4   = t3_q;
    // w of a*t is dropped, but its saturation still flags the item
    w4   = p3_q[0] - p3_q[5] - p3_q[10] - p3_q[15];
    if (c3_q.op == qru_pkg::OP_ROTATE) begin
      if (w4 > WMAX || w4 < WMIN) ovf4 = 1'b1;
      r4[0] = '0;
      r4[1] = sat(p3_q[1] + p3_q[4] + p3_q[11] - p3_q[14], ovf4);
      r4[2] = sat(p3_q[2] + p3_q[8] + p3_q[13] - p3_q[7], ovf4);
      r4[3] = sat(p3_q[3] + p3_q[12] + p3_q[6] - p3_q[9], ovf4);
    end
  end

  ctl_t  c4_q;
  word_t r4_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c4_q <= '0;
    else if (adv) begin
      c4_q <= '{valid: c3_q.valid, op: c3_q.op, row: c3_q.row,
                last: c3_q.last, ovf: ovf4};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) r4_q <= r4;
  end

  assign out_valid_o = c4_q.valid;
  assign out_x_o     = r4_q[1];
  assign out_y_o     = r4_q[2];
  assign out_z_o     = r4_q[3];
  assign out_w_o     = r4_q[0];
  assign row_o       = c4_q.row;
  assign overflow_o  = c4_q.ovf;
  assign last_o      = c4_q.last;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quaternion rotation unit: random and corner
// items on the input channel, a predictor of the fixed-point results, and an
// in-order scoreboard on the output channel, with random idling on both sides.
// ----------------------------------------------------------------------------
typedef struct {
  logic signed [15:0] x, y, z, w;
  logic [1:0]         row;
  logic               ovf;
  logic               last;
} qru_result_t;

// Expected results in order; compares each arriving result with the oldest
class qru_scoreboard;
  qru_result_t pending[$];
  int          errors;

  // product of two words, rounded to nearest with ties upward
  static function longint rmul(longint p, longint q);
    return (p * q + 2048) >>> 12;
  endfunction

  static function longint clip(longint v, ref bit ovf);
    if (v > 32767) begin
      ovf = 1;
      return 32767;
    end
    if (v < -32768) begin
      ovf = 1;
      return -32768;
    end
    return v;
  endfunction

  // Hamilton product, order w x y z
  static function void hamilton(longint p[4], longint q[4], ref longint r[4],
                                ref bit ovf);
    r[0] = clip(rmul(p[0], q[0]) - rmul(p[1], q[1]) - rmul(p[2], q[2])
                - rmul(p[3], q[3]), ovf);
    r[1] = clip(rmul(p[0], q[1]) + rmul(p[1], q[0]) + rmul(p[2], q[3])
                - rmul(p[3], q[2]), ovf);
    r[2] = clip(rmul(p[0], q[2]) + rmul(p[2], q[0]) + rmul(p[3], q[1])
                - rmul(p[1], q[3]), ovf);
    r[3] = clip(rmul(p[0], q[3]) + rmul(p[3], q[0]) + rmul(p[1], q[2])
                - rmul(p[2], q[1]), ovf);
  endfunction

  function void push(longint x, longint y, longint z, longint w, int row, bit ovf,
                     bit last);
    qru_result_t e;
    e.x = x[15:0]; e.y = y[15:0]; e.z = z[15:0]; e.w = w[15:0];
    e.row = row[1:0]; e.ovf = ovf; e.last = last;
    pending.push_back(e);
  endfunction

  function void note_item(qru_pkg::op_e op, logic signed [15:0] aq[4],
                          logic signed [15:0] bq[4]);
    longint a[4], b[4], r[4], t[4], v[4], c[4];
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz, m0, m1, m2;
    bit ovf;
    ovf = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = aq[i];
      b[i] = bq[i];
    end
    case (op)
      qru_pkg::OP_QMUL: begin
        hamilton(a, b, r, ovf);
        push(r[1], r[2], r[3], r[0], 0, ovf, 1);
      end
      qru_pkg::OP_ROTATE: begin
        v[0] = 0; v[1] = b[1]; v[2] = b[2]; v[3] = b[3];
        c[0] = a[0];
        for (int i = 1; i < 4; i++) c[i] = clip(-a[i], ovf);
        hamilton(v, c, t, ovf);
        hamilton(a, t, r, ovf);
        push(r[1], r[2], r[3], 0, 0, ovf, 1);
      end
      qru_pkg::OP_MATRIX: begin
        xx = rmul(a[1], a[1]); yy = rmul(a[2], a[2]); zz = rmul(a[3], a[3]);
        xy = rmul(a[1], a[2]); xz = rmul(a[1], a[3]); yz = rmul(a[2], a[3]);
        wx = rmul(a[0], a[1]); wy = rmul(a[0], a[2]); wz = rmul(a[0], a[3]);
        m0 = clip(4096 - 2 * (yy + zz), ovf);
        m1 = clip(2 * (xy - wz), ovf);
        m2 = clip(2 * (xz + wy), ovf);
        push(m0, m1, m2, 0, 0, ovf, 0);
        ovf = 0;
        m0 = clip(2 * (xy + wz), ovf);
        m1 = clip(4096 - 2 * (xx + zz), ovf);
        m2 = clip(2 * (yz - wx), ovf);
        push(m0, m1, m2, 0, 1, ovf, 0);
        ovf = 0;
        m0 = clip(2 * (xz - wy), ovf);
        m1 = clip(2 * (yz + wx), ovf);
        m2 = clip(4096 - 2 * (xx + yy), ovf);
        push(m0, m1, m2, 0, 2, ovf, 0);
        push(0, 0, 0, 4096, qru_pkg::ROW_LAST, 0, 1);
      end
      default: begin
        r[1] = clip(rmul(a[2], b[3]) - rmul(a[3], b[2]), ovf);
        r[2] = clip(rmul(a[3], b[1]) - rmul(a[1], b[3]), ovf);
        r[3] = clip(rmul(a[1], b[2]) - rmul(a[2], b[1]), ovf);
        push(r[1], r[2], r[3], 0, 0, ovf, 1);
      end
    endcase
  endfunction

  function void check_result(qru_result_t got);
    qru_result_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result x=%0d y=%0d z=%0d", got.x, got.y, got.z);
      return;
    end
    e = pending.pop_front();
    if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.w !== e.w ||
        got.row !== e.row || got.ovf !== e.ovf || got.last !== e.last) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch exp x=%0d y=%0d z=%0d w=%0d row=%0d ovf=%0b last=%0b",
                  " got x=%0d y=%0d z=%0d w=%0d row=%0d ovf=%0b last=%0b"},
                 e.x, e.y, e.z, e.w, e.row, e.ovf, e.last,
                 got.x, got.y, got.z, got.w, got.row, got.ovf, got.last);
    end
  endfunction
endclass

module tb;
  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [1:0] op_i, row_o;
  logic signed [15:0] a_w_i, a_x_i, a_y_i, a_z_i, b_w_i, b_x_i, b_y_i, b_z_i;
  logic signed [15:0] out_x_o, out_y_o, out_z_o, out_w_o;
  logic overflow_o, last_o;
  bit   calm;
  qru_scoreboard board;

  quaternion_rotation_unit_top DUT (.*);

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

  // corner-biased random word
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h1000;
      4: return 16'hf000;
      default: return 16'($urandom);
    endcase
  endfunction

  // drive one item and hold until accepted; valid stays up for the next one
  task automatic send_item(qru_pkg::op_e op, logic [15:0] a[4], logic [15:0] b[4]);
    logic signed [15:0] sa[4], sb[4];
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; op_i <= op;
    a_w_i <= a[0]; a_x_i <= a[1]; a_y_i <= a[2]; a_z_i <= a[3];
    b_w_i <= b[0]; b_x_i <= b[1]; b_y_i <= b[2]; b_z_i <= b[3];
    for (int i = 0; i < 4; i++) begin
      sa[i] = a[i];
      sb[i] = b[i];
    end
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(op, sa, sb);
  endtask

  task automatic send_random(qru_pkg::op_e op);
    logic [15:0] a[4], b[4];
    for (int i = 0; i < 4; i++) begin
      a[i] = pick_word();
      b[i] = pick_word();
    end
    send_item(op, a, b);
  endtask

  // output side: sample results, random stall
  always @(posedge clk_i) begin
    qru_result_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.x = out_x_o; got.y = out_y_o; got.z = out_z_o; got.w = out_w_o;
        got.row = row_o; got.ovf = overflow_o; got.last = last_o;
        board.check_result(got);
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 11);
    end
  end

  initial begin
    logic [15:0] a[4], b[4];
    int waited;
    board = new();
    calm = 0;
    rst_ni = 0; in_valid_i = 0; out_stall_i = 0; op_i = qru_pkg::OP_QMUL;
    {a_w_i, a_x_i, a_y_i, a_z_i, b_w_i, b_x_i, b_y_i, b_z_i} = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: identity, unit axes, extremes, all ops
    a = '{16'h1000, 0, 0, 0}; b = '{16'h1000, 16'h1000, 16'h2000, 16'h3000};
    for (int o = 0; o < 4; o++) send_item(qru_pkg::op_e'(o), a, b);
    a = '{16'h0b50, 16'h0b50, 0, 0};
    for (int o = 0; o < 4; o++) send_item(qru_pkg::op_e'(o), a, b);
    a = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
    b = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
    for (int o = 0; o < 4; o++) send_item(qru_pkg::op_e'(o), a, b);
    a = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
    b = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
    for (int o = 0; o < 4; o++) send_item(qru_pkg::op_e'(o), a, b);
    a = '{16'h0001, 16'hffff, 16'h0800, 16'hf800};
    b = '{16'hffff, 16'h0001, 16'hf800, 16'h0800};
    for (int o = 0; o < 4; o++) send_item(qru_pkg::op_e'(o), a, b);
    in_valid_i <= 0;

    // hold off until the pipeline drains
    while (board.pending.size() != 0) @(posedge clk_i);

    // random, with a stretch of no idling in the middle
    for (int n = 0; n < 110; n++) begin
      calm = (n >= 40 && n < 70);
      send_random(qru_pkg::op_e'($urandom_range(0, 3)));
    end
    in_valid_i <= 0;
    calm = 0;

    waited = 0;
    while (board.pending.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule

// ===== quaternion_rotation_unit_top.f =====
sv/qru_pkg.sv
sv/quaternion_rotation_unit_top.sv
bench/tb.sv
